@@ rtl/adres_pkg.sv @@
// Package for the ADC-average-to-resistance block: widths, constants,
// queue entry types and the back-end state type. Depends on nothing.
package adres_pkg;

   localparam int SAMPLE_W = 12;
   localparam int CHAN_W   = 4;
   localparam int REF_W    = 16;
   localparam int RES_W    = 35;
   localparam int SUM_W    = 16;
   localparam int SEEN_W   = 5;

   // AVERAGE_COUNT must stay a power of two: the average is a right shift
   localparam int AVERAGE_COUNT = 16;
   localparam int DISCARD_COUNT = 2;
   localparam int AVG_SHIFT     = $clog2(AVERAGE_COUNT);

   localparam logic [SEEN_W-1:0] TOTAL_SEEN   = SEEN_W'(DISCARD_COUNT + AVERAGE_COUNT);
   localparam logic [SEEN_W-1:0] DISCARD_SEEN = SEEN_W'(DISCARD_COUNT);

   localparam logic [SAMPLE_W-1:0] FULL_SCALE      = 12'hFFF;
   localparam logic [CHAN_W-1:0]   BANDGAP_CHANNEL = 4'd15;
   localparam logic [RES_W-1:0]    MIN_CENTIOHM    = 35'd100;
   localparam logic [RES_W-1:0]    SAT_CENTIOHM    = 35'd26830029000;
   localparam logic [REF_W-1:0]    REF_RESET       = 16'd300;
   localparam logic [6:0]          CENTI_SCALE     = 7'd100;

   localparam int PROD_W    = REF_W + SAMPLE_W;   // reference * average
   localparam int NUM_W     = RES_W;              // 100 * reference * average
   localparam int DIVD_W    = NUM_W + 1;          // 2*num + den
   localparam int DIVS_W    = SAMPLE_W + 1;       // 2*den
   localparam int DIV_STEPS = DIVD_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam int QUEUE_DEPTH_DEF = 2;

   typedef struct packed {
      logic [CHAN_W-1:0]   channel;
      logic [SAMPLE_W-1:0] avg;
   } pend_type;

   typedef struct packed {
      logic     valid;
      pend_type data;
   } push_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_SCALE,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

@@ rtl/adres_if.sv @@
// Channel interfaces of the block: sample requests, resistance responses
// and the reference-resistor register write. Depends on adres_pkg.
interface adres_req_if import adres_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic [CHAN_W-1:0]   channel;
   logic                burst_start;
   modport source (output valid, sample, channel, burst_start, input ready);
   modport sink   (input valid, sample, channel, burst_start, output ready);
endinterface

interface adres_rsp_if import adres_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] result_channel;
   logic [RES_W-1:0]  resistance_centiohm;
   logic              saturated;
   modport source (output valid, result_channel, resistance_centiohm, saturated,
                   input ready);
   modport sink   (input valid, result_channel, resistance_centiohm, saturated,
                   output ready);
endinterface

interface adres_csr_if import adres_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [REF_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ rtl/adres_front.sv @@
// Front end: takes samples, tracks the burst, sums the averaged samples and
// queues channel and average (not for bandgap). Depends on adres_pkg.
module adres_front import adres_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic [CHAN_W-1:0]   channel,
   input  logic                burst_start,
   output push_type            push
);

   logic [SEEN_W-1:0] seen_ff, seen_in, seen_base;
   logic [SUM_W-1:0]  sum_ff, sum_in, sum_base;
   logic [CHAN_W-1:0] chan_ff, chan_in;

   always_comb begin
      seen_base = burst_start ? '0 : seen_ff;
      sum_base  = burst_start ? '0 : sum_ff;
      chan_in   = burst_start ? channel : chan_ff;
      seen_in   = seen_base;
      sum_in    = sum_base;
      push      = '0;
      // past the end of a burst: drop samples until the next start
      if (seen_base < TOTAL_SEEN) begin
         if (seen_base >= DISCARD_SEEN) begin
            sum_in = sum_base + SUM_W'(sample);
         end
         seen_in = seen_base + SEEN_W'(1);
         push.valid = accept && (seen_in == TOTAL_SEEN) && (chan_in != BANDGAP_CHANNEL);
      end
      push.data.channel = chan_in;
      push.data.avg     = sum_in[SUM_W-1:AVG_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         sum_ff  <= '0;
         chan_ff <= '0;
      end else if (accept) begin
         seen_ff <= seen_in;
         sum_ff  <= sum_in;
         chan_ff <= chan_in;
      end
   end

endmodule

@@ rtl/adres_queue.sv @@
// Short queue of finished burst averages between front and back end.
// Depends on adres_pkg.
module adres_queue import adres_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     full,
   output push_type head,
   input  logic     pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pend_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff;
   logic                 do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.data  = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      next_ptr = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (do_pop)  rd_ptr_ff <= next_ptr(rd_ptr_ff);
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

@@ rtl/adres_back.sv @@
// Back end: multiplies reference by average, scales to centiohms, divides
// one quotient bit a cycle and holds the result word. Depends on adres_pkg.
module adres_back import adres_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [REF_W-1:0]  ref_res,
   input  push_type          head,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [CHAN_W-1:0] out_channel,
   output logic [RES_W-1:0]  out_res,
   output logic              out_sat
);

   back_state_type state_ff, state_in;

   logic [CHAN_W-1:0]   chan_ff;
   logic [SAMPLE_W-1:0] avg_ff;
   logic [SAMPLE_W-1:0] den_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                sat_ff;
   logic [DIVD_W-1:0]   quo_ff;
   logic [DIVS_W-1:0]   rem_ff;
   logic [CNT_W-1:0]    cnt_ff;

   logic                out_valid_ff;
   logic [CHAN_W-1:0]   out_chan_ff;
   logic [RES_W-1:0]    out_res_ff;
   logic                out_sat_ff;

   logic                load_out, div_last;
   logic [DIVS_W-1:0]   divisor;
   logic [DIVS_W:0]     rem_sh;
   logic                q_bit;
   logic [DIVS_W-1:0]   rem_in;
   logic [NUM_W-1:0]    num;
   logic [RES_W-1:0]    res_val;

   assign divisor  = {den_ff, 1'b0};
   assign rem_sh   = {rem_ff, quo_ff[DIVD_W-1]};
   assign q_bit    = (rem_sh >= {1'b0, divisor});
   assign rem_in   = q_bit ? DIVS_W'(rem_sh - {1'b0, divisor}) : rem_sh[DIVS_W-1:0];
   assign num      = NUM_W'(prod_ff) * NUM_W'(CENTI_SCALE);
   assign div_last = (cnt_ff == CNT_W'(DIV_STEPS - 1));

   always_comb begin
      if (sat_ff) begin
         res_val = SAT_CENTIOHM;
      end else if (quo_ff < DIVD_W'(MIN_CENTIOHM)) begin
         res_val = MIN_CENTIOHM;
      end else begin
         res_val = quo_ff[RES_W-1:0];
      end
   end

   // outputs of the state machine
   always_comb begin
      pop      = (state_ff == BK_IDLE) && head.valid;
      load_out = (state_ff == BK_DONE) && (!out_valid_ff || out_ready);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (head.valid) state_in = BK_MUL;
         BK_MUL:   state_in = (avg_ff == FULL_SCALE) ? BK_DONE : BK_SCALE;
         BK_SCALE: state_in = BK_DIV;
         BK_DIV:   if (div_last) state_in = BK_DONE;
         BK_DONE:  if (load_out) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         chan_ff <= head.data.channel;
         avg_ff  <= head.data.avg;
      end
      if (state_ff == BK_MUL) begin
         prod_ff <= PROD_W'(ref_res) * PROD_W'(avg_ff);
         den_ff  <= FULL_SCALE - avg_ff;
         sat_ff  <= (avg_ff == FULL_SCALE);
      end
      if (state_ff == BK_SCALE) begin
         quo_ff <= {num, 1'b0} + DIVD_W'(den_ff);
         rem_ff <= '0;
         cnt_ff <= '0;
      end
      if (state_ff == BK_DIV) begin
         quo_ff <= {quo_ff[DIVD_W-2:0], q_bit};
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (load_out) begin
         out_chan_ff <= chan_ff;
         out_res_ff  <= res_val;
         out_sat_ff  <= sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_channel = out_chan_ff;
   assign out_res     = out_res_ff;
   assign out_sat     = out_sat_ff;

endmodule

@@ rtl/adc_average_to_resistance.sv @@
// Burst-average converter samples and convert to divider resistance.
// Throughput: one sample word per cycle unless the queue is full; a burst of 18
// samples yields one result (none on the bandgap channel). From the last sample
// of a burst to the result word: queue, multiply, scale, bit-serial divider,
// output register. The back end takes a new average only after loading its last
// result; the queue holds finished averages and the front stalls only when it fills.
// Reset (synchronous): burst open on channel 0, queue and results empty, reference 300.
module adc_average_to_resistance import adres_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   adres_req_if.sink   req_ch,
   adres_rsp_if.source rsp_ch,
   adres_csr_if.sink   csr_ch
);

   logic [REF_W-1:0] ref_ff;
   push_type         front_push;
   push_type         q_head;
   logic             q_full;
   logic             q_pop;
   logic             req_accept;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= REF_RESET;
      end else if (csr_ch.valid) begin
         ref_ff <= csr_ch.data;
      end
   end

   // hold samples while the queue is full
   assign req_ch.ready = !q_full;
   assign req_accept   = req_ch.valid && !q_full;

   adres_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .sample      (req_ch.sample),
      .channel     (req_ch.channel),
      .burst_start (req_ch.burst_start),
      .push        (front_push)
   );

   adres_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (front_push),
      .full  (q_full),
      .head  (q_head),
      .pop   (q_pop)
   );

   adres_back u_back (
      .clock       (clock),
      .reset       (reset),
      .ref_res     (ref_ff),
      .head        (q_head),
      .pop         (q_pop),
      .out_valid   (rsp_ch.valid),
      .out_ready   (rsp_ch.ready),
      .out_channel (rsp_ch.result_channel),
      .out_res     (rsp_ch.resistance_centiohm),
      .out_sat     (rsp_ch.saturated)
   );

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(front_push.valid && q_full))
      else $error("push into full queue");

   a_min_value: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.resistance_centiohm >= MIN_CENTIOHM))
      else $error("result below one ohm");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.saturated) |-> (rsp_ch.resistance_centiohm == SAT_CENTIOHM))
      else $error("saturated result not at maximum");

   a_no_bandgap: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.result_channel != BANDGAP_CHANNEL))
      else $error("result on bandgap channel");
`endif

endmodule
